[src/circle_octant_rasterizer_top_assert.svh]
// Assertion macros for the checker file (cor_checker.sv).
`ifndef CIRCLE_OCTANT_RASTERIZER_TOP_ASSERT_SVH
`define CIRCLE_OCTANT_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define COR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define COR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always checked (reset behavior)
`define COR_ASSERT_RAW_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/cor_pkg.sv]
`timescale 1ns / 1ps

package cor_pkg;

    localparam int unsigned MAX_DIM = 4096;

    localparam int unsigned DIM_W   = 13;  // image_width / image_height
    localparam int unsigned ORG_W   = 12;  // origin and centre coordinates
    localparam int unsigned END_W   = 14;  // window-relative end point
    localparam int unsigned PIX_W   = 16;  // output coordinates
    localparam int unsigned VAL_W   = 8;
    localparam int unsigned R2_W    = 30;  // squared radius
    localparam int unsigned ROOT_W  = 15;  // isqrt of an R2_W value
    localparam int unsigned STEP_W  = 15;
    localparam int unsigned MUL_W   = 16;
    localparam int unsigned PROD_W  = 2 * MUL_W;

    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ORIGIN_X     = 2'd2;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd3;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [VAL_W-1:0] INK_BLACK = '0;
    localparam logic [VAL_W-1:0] INK_WHITE = '1;

    // clamp a dimension register to MAX_DIM
    function automatic logic [DIM_W:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] r;
        r = {1'b0, v};
        if (r > (DIM_W+1)'(MAX_DIM)) begin
            r = (DIM_W+1)'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

[src/cor_isqrt.sv]
`timescale 1ns / 1ps

// Bit-pair integer square root, one result bit per cycle.
module cor_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [cor_pkg::R2_W-1:0]    radicand,
    output logic                        done,
    output logic [cor_pkg::ROOT_W-1:0]  root
);
    import cor_pkg::*;

    localparam int unsigned BIT_W = R2_W - 1;

    logic [R2_W-1:0]  rem_reg, rem_next;
    logic [R2_W-1:0]  res_reg, res_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [R2_W:0]    trial;

    assign trial = {1'b0, res_reg} + {2'b00, bit_reg};

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = {1'b1, {(BIT_W-1){1'b0}}};
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[R2_W-1:0];
                res_next = (res_reg >> 1) + {1'b0, bit_reg};
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

[src/circle_octant_rasterizer_top.sv]
`timescale 1ns / 1ps

// Circle rasterizer, eight-way symmetric.
// Input channel (s_*): one transaction per command. func = start loads a
// centre, end point and ink; the squared radius is formed with the shared
// 16x16 multiplier as adx^2 plus ady^2 and nothing is produced. A start
// whose centre lies outside the clamped image leaves the block inactive.
// func = tick runs one step k: k*k and (k+1)*(k+1) on the multiplier,
// then a bit-pair square root, then eight output transactions (m_*), one
// per cycle while the receiver accepts, the eighth of the final step
// flagged last. A tick with no circle running, or past the end, produces
// no points. s_ready is high only while the sequencer is idle.
// Output: a single output register; when the receiver stalls, the point
// holds and the sequencer waits, and the last point may still be pending
// while the next command is taken.
// Config: APB, registers at byte addresses 0/4/8/12 (width, height, origin
// x, origin y); pready is always high. Width/height apply to clipping at
// once, origins only at the next start. Write only while idle.
// Reset (aresetn low, synchronous): registers to 4096/4096/0/0, no circle
// running, output empty.
module circle_octant_rasterizer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cor_pkg::APB_AW-1:0]   paddr,
    input  logic [cor_pkg::APB_DW-1:0]   pwdata,
    output logic [cor_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // command channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [cor_pkg::ORG_W-1:0]    s_center_x,
    input  logic [cor_pkg::ORG_W-1:0]    s_center_y,
    input  logic signed [cor_pkg::END_W-1:0] s_end_x,
    input  logic signed [cor_pkg::END_W-1:0] s_end_y,
    input  logic                         s_ink_white,
    // point channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [cor_pkg::PIX_W-1:0] m_pixel_x,
    output logic signed [cor_pkg::PIX_W-1:0] m_pixel_y,
    output logic [cor_pkg::VAL_W-1:0]    m_pixel_value,
    output logic                         m_visible,
    output logic                         m_last
);
    import cor_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;  // adx^2
    localparam logic [3:0] ST_SQY  = 4'd2;  // ady^2, latch adx^2
    localparam logic [3:0] ST_SUM  = 4'd3;  // r2 = adx^2 + ady^2
    localparam logic [3:0] ST_KK   = 4'd4;  // k^2
    localparam logic [3:0] ST_CHK  = 4'd5;  // end test, launch isqrt, (k+1)^2
    localparam logic [3:0] ST_FIN  = 4'd6;  // final-step test
    localparam logic [3:0] ST_ROOT = 4'd7;  // wait for isqrt
    localparam logic [3:0] ST_EMIT = 4'd8;  // eight points

    localparam int unsigned SW = ORG_W + 5;  // start arithmetic width

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [ORG_W-1:0] origin_x_reg, origin_y_reg;
    logic             cfg_wr;

    // sequencer and circle state
    logic [3:0]        state_reg, state_next;
    logic              active_reg, active_next;
    logic              start_ok_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ORG_W-1:0]  cx_reg, cy_reg;
    logic              ink_reg;
    logic [ROOT_W-1:0] adx_reg, ady_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              fin_reg;
    logic [2:0]        idx_reg;

    // shared multiplier
    logic [MUL_W-1:0]  mul_op;
    logic [PROD_W-1:0] prod_reg;

    // output register
    logic                    m_valid_reg;
    logic signed [PIX_W-1:0] px_reg, py_reg;
    logic [VAL_W-1:0]        pval_reg;
    logic                    vis_reg, last_reg;

    // isqrt
    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [R2_W-1:0]   sq_radicand;

    logic s_fire, out_free;
    logic [DIM_W:0] w_eff, h_eff;
    logic [PROD_W-1:0] half_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign w_eff    = clamp_dim(width_reg);
    assign h_eff    = clamp_dim(height_reg);
    assign half_ext = {{(PROD_W-R2_W+1){1'b0}}, r2_reg[R2_W-1:1]};

    // ---------------------------------------------------------------
    // APB
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(MAX_DIM);
            height_reg   <= DIM_W'(MAX_DIM);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  width_reg    <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg   <= pwdata[DIM_W-1:0];
                REG_ORIGIN_X:     origin_x_reg <= pwdata[ORG_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg <= pwdata[ORG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(height_reg);
            REG_ORIGIN_X:     prdata = APB_DW'(origin_x_reg);
            REG_ORIGIN_Y:     prdata = APB_DW'(origin_y_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // start-point arithmetic: |cx - (end - origin)|, narrow adds only
    // ---------------------------------------------------------------
    logic signed [SW-1:0] ex_s, ey_s, dx_s, dy_s;
    logic [ROOT_W-1:0]    adx_in, ady_in;
    logic                 centre_in;

    always_comb begin
        ex_s = SW'(s_end_x) - $signed({{(SW-ORG_W){1'b0}}, origin_x_reg});
        ey_s = SW'(s_end_y) - $signed({{(SW-ORG_W){1'b0}}, origin_y_reg});
        dx_s = $signed({{(SW-ORG_W){1'b0}}, s_center_x}) - ex_s;
        dy_s = $signed({{(SW-ORG_W){1'b0}}, s_center_y}) - ey_s;
        adx_in = dx_s[SW-1] ? ROOT_W'(-dx_s) : ROOT_W'(dx_s);
        ady_in = dy_s[SW-1] ? ROOT_W'(-dy_s) : ROOT_W'(dy_s);
        centre_in = ({{(DIM_W-ORG_W+1){1'b0}}, s_center_x} < w_eff) &&
                    ({{(DIM_W-ORG_W+1){1'b0}}, s_center_y} < h_eff);
    end

    // ---------------------------------------------------------------
    // shared multiplier: squares one operand, product registered
    // ---------------------------------------------------------------
    always_comb begin
        case (state_reg)
            ST_SQX:  mul_op = MUL_W'(adx_reg);
            ST_SQY:  mul_op = MUL_W'(ady_reg);
            ST_KK:   mul_op = MUL_W'(step_reg);
            ST_CHK:  mul_op = MUL_W'(step_reg) + MUL_W'(1);
            default: mul_op = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_op * mul_op;
    end

    // ---------------------------------------------------------------
    // square root unit
    // ---------------------------------------------------------------
    assign sq_radicand = r2_reg - prod_reg[R2_W-1:0];
    assign sq_start    = (state_reg == ST_CHK) && (prod_reg <= half_ext);

    cor_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    // ---------------------------------------------------------------
    // point generation: idx[2] swaps k/root, idx[1] negates x, idx[0] y
    // ---------------------------------------------------------------
    logic [ROOT_W-1:0]       sel_x, sel_y;
    logic signed [PIX_W-1:0] pt_x, pt_y;
    logic                    pt_vis;

    always_comb begin
        sel_x = idx_reg[2] ? root_reg : ROOT_W'(step_reg);
        sel_y = idx_reg[2] ? ROOT_W'(step_reg) : root_reg;
        pt_x = idx_reg[1] ?
               $signed(PIX_W'(cx_reg) - PIX_W'(sel_x)) :
               $signed(PIX_W'(cx_reg) + PIX_W'(sel_x));
        pt_y = idx_reg[0] ?
               $signed(PIX_W'(cy_reg) - PIX_W'(sel_y)) :
               $signed(PIX_W'(cy_reg) + PIX_W'(sel_y));
        pt_vis = !pt_x[PIX_W-1] && !pt_y[PIX_W-1] &&
                 (pt_x[PIX_W-2:0] < (PIX_W-1)'(w_eff)) &&
                 (pt_y[PIX_W-2:0] < (PIX_W-1)'(h_eff));
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_func == FUNC_START) begin
                        active_next = 1'b0;
                        state_next  = ST_SQX;
                    end else if (active_reg) begin
                        state_next = ST_KK;
                    end
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SUM;
            ST_SUM: begin
                active_next = start_ok_reg;
                state_next  = ST_IDLE;
            end
            ST_KK:   state_next = ST_CHK;
            ST_CHK: begin
                if (prod_reg > half_ext) begin
                    active_next = 1'b0;   // circle finished
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_ROOT;
            ST_ROOT: begin
                if (sq_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && idx_reg == 3'd7) begin
                    if (fin_reg) begin
                        active_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            r2_reg   <= '0;
        end else begin
            case (state_reg)
                ST_SQY: r2_reg <= prod_reg[R2_W-1:0];
                ST_SUM: begin
                    r2_reg   <= r2_reg + prod_reg[R2_W-1:0];
                    step_reg <= '0;
                end
                ST_EMIT: begin
                    if (out_free && idx_reg == 3'd7) begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_func == FUNC_START) begin
            cx_reg       <= s_center_x;
            cy_reg       <= s_center_y;
            ink_reg      <= s_ink_white;
            adx_reg      <= adx_in;
            ady_reg      <= ady_in;
            start_ok_reg <= centre_in;
        end
        if (state_reg == ST_FIN) begin
            fin_reg <= (prod_reg > half_ext);
        end
        if (state_reg == ST_ROOT && sq_done) begin
            root_reg <= sq_root;
            idx_reg  <= '0;
        end else if (state_reg == ST_EMIT && out_free) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic load_pt;
    assign load_pt = (state_reg == ST_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_pt) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pt) begin
            px_reg   <= pt_x;
            py_reg   <= pt_y;
            pval_reg <= ink_reg ? INK_WHITE : INK_BLACK;
            vis_reg  <= pt_vis;
            last_reg <= (idx_reg == 3'd7) && fin_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_value = pval_reg;
    assign m_visible     = vis_reg;
    assign m_last        = last_reg;

endmodule

[src/cor_checker.sv]
`timescale 1ns / 1ps

`include "circle_octant_rasterizer_top_assert.svh"

module cor_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_func,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [cor_pkg::PIX_W-1:0]  m_pixel_x,
    input logic signed [cor_pkg::PIX_W-1:0]  m_pixel_y,
    input logic [cor_pkg::VAL_W-1:0]         m_pixel_value,
    input logic                              m_visible
);
    import cor_pkg::*;

    // output register empty after reset
    `COR_ASSERT_RAW_NEXT(a_reset_empty, aclk, !aresetn, !m_valid, "output valid after reset")

    // a start transaction keeps the sequencer busy for the radius setup
    `COR_ASSERT_NEXT(a_start_busy, aclk, aresetn, s_valid && s_ready && s_func == FUNC_START, !s_ready, "ready right after start transaction")

    // stalled point stays offered
    `COR_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "point dropped while stalled")

    // ink is black or white only
    `COR_ASSERT_SAME(a_ink_value, aclk, aresetn, m_valid, m_pixel_value == INK_BLACK || m_pixel_value == INK_WHITE, "bad pixel value")

    // a visible point never has a negative coordinate
    `COR_ASSERT_SAME(a_vis_range, aclk, aresetn, m_valid && m_visible, !m_pixel_x[PIX_W-1] && !m_pixel_y[PIX_W-1], "visible point off image")

endmodule

bind circle_octant_rasterizer_top cor_checker u_cor_checker (.*);
